FILE: rtl/core/tpcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcf_pkg - shared types and constants of the TS continuity filter
// Field layouts, table entry format, status codes and packet geometry.
// ----------------------------------------------------------------------------
package tpcf_pkg;

    // Table geometry
    localparam int PID_BITS    = 13;
    localparam int TABLE_DEPTH = 1 << PID_BITS;
    localparam int ENTRY_BITS  = 8;

    // Packet geometry
    localparam int PACKET_BYTES = 188;
    localparam int HEADER_BYTES = 4;
    localparam int ADAPT_MAX    = PACKET_BYTES - 5;

    localparam logic [7:0] SYNC_VALUE   = 8'h47;
    localparam logic [7:0] OFFSET_HDR   = 8'(HEADER_BYTES);
    localparam logic [7:0] OFFSET_FULL  = 8'(PACKET_BYTES);
    localparam logic [7:0] ADAPT_LIMIT  = 8'(ADAPT_MAX);

    // Sync modes held per PID
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_AWAIT  = 2'd0;
    localparam t_mode MODE_LOST   = 2'd1;
    localparam t_mode MODE_SYNCED = 2'd2;

    // Result status codes
    typedef logic [3:0] t_status;
    localparam t_status ST_OK         = 4'd0;
    localparam t_status ST_RESYNC     = 4'd1;
    localparam t_status ST_BADSYNC    = 4'd2;
    localparam t_status ST_UNKNOWN    = 4'd3;
    localparam t_status ST_AWAIT      = 4'd4;
    localparam t_status ST_UNSYNCED   = 4'd5;
    localparam t_status ST_DISCONT    = 4'd6;
    localparam t_status ST_ADAPT_LONG = 4'd7;
    localparam t_status ST_REGISTERED = 4'd8;
    localparam t_status ST_ALREADY    = 4'd9;

    // One PID table entry
    typedef struct packed {
        logic       known;
        logic       kind;
        t_mode      mode;
        logic [3:0] cc;
    } t_entry;

    // Classified item passed from front to back
    typedef struct packed {
        logic        op;
        logic        sync_ok;
        logic        start;
        logic [12:0] pid;
        logic [3:0]  cc;
        logic        rkind;
        logic        adapt_long;
        logic [7:0]  off;
        logic [7:0]  len;
    } t_item;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // One result
    typedef struct packed {
        t_status     status;
        logic [12:0] pid;
        logic        kind;
        logic        start;
        logic        mark;
        logic [7:0]  off;
        logic [7:0]  len;
    } t_result;

endpackage

FILE: rtl/core/tpcf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcf_ram - generic single-port RAM
// One read or write address per cycle, registered read data (read-first).
// ----------------------------------------------------------------------------
module tpcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tpcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcf_front - header classifier
// Checks the sync byte and works out payload offset and length up front.
// ----------------------------------------------------------------------------
module tpcf_front (
    input  logic          i_op,
    input  logic [7:0]    i_sync_byte,
    input  logic          i_payload_start,
    input  logic [12:0]   i_pid,
    input  logic [1:0]    i_adaptation_control,
    input  logic [3:0]    i_continuity,
    input  logic [7:0]    i_adaptation_length,
    input  logic          i_register_kind,
    output tpcf_pkg::t_item o_item
);

    logic       adapt_present;
    logic       adapt_long;
    logic [7:0] adapt_sum;
    logic [7:0] off;

    // Adaptation field: only bit 1 of the control bits counts
    assign adapt_present = i_adaptation_control[1];
    assign adapt_long    = adapt_present && (i_adaptation_length > tpcf_pkg::ADAPT_LIMIT);
    // Fits in 8 bits whenever the length is in range
    assign adapt_sum     = i_adaptation_length + tpcf_pkg::OFFSET_HDR + 8'd1;

    // Payload offset within the packet
    always_comb begin
        if (adapt_long) begin
            off = tpcf_pkg::OFFSET_FULL;
        end else if (adapt_present) begin
            off = adapt_sum;
        end else begin
            off = tpcf_pkg::OFFSET_HDR;
        end
    end

    // Pack the classified item
    always_comb begin
        o_item.op         = i_op;
        o_item.sync_ok    = (i_sync_byte == tpcf_pkg::SYNC_VALUE);
        o_item.start      = i_payload_start;
        o_item.pid        = i_pid;
        o_item.cc         = i_continuity;
        o_item.rkind      = i_register_kind;
        o_item.adapt_long = adapt_long;
        o_item.off        = off;
        o_item.len        = tpcf_pkg::OFFSET_FULL - off;
    end

endmodule

FILE: rtl/core/tpcf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcf_queue - two-entry item queue
// Decouples the classifier from the table sequencer.
// ----------------------------------------------------------------------------
module tpcf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpcf_pkg::t_item   i_item,
    input  logic              i_pop,
    output tpcf_pkg::t_item   o_head,
    output tpcf_pkg::t_q_stat o_stat
);

    tpcf_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: rtl/core/tpcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcf_back - PID table sequencer
// Clears the table after reset, then reads one entry per item, writes it
// back updated where the item calls for it, and registers the result.
// ----------------------------------------------------------------------------
module tpcf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpcf_pkg::t_item   i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_valid,
    output tpcf_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_READ  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [tpcf_pkg::PID_BITS-1:0] r_clr_addr;
    logic [tpcf_pkg::PID_BITS-1:0] n_clr_addr;
    logic                          r_valid;
    logic                          n_valid;
    tpcf_pkg::t_result             r_result;
    tpcf_pkg::t_result             n_result;

    logic                          ram_we;
    logic [tpcf_pkg::PID_BITS-1:0] ram_addr;
    tpcf_pkg::t_entry              ram_wdata;
    logic [tpcf_pkg::ENTRY_BITS-1:0] ram_rdata;
    tpcf_pkg::t_entry              ent;

    logic                          pass;
    logic                          mark;
    logic [3:0]                    cc_next;

    tpcf_ram #(
        .WIDTH (tpcf_pkg::ENTRY_BITS),
        .DEPTH (tpcf_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign ent     = tpcf_pkg::t_entry'(ram_rdata);
    assign cc_next = ent.cc + 4'd1;

    // Sequencer: clear sweep, table read, then update and result
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_valid    = 1'b0;
        n_result   = r_result;
        ram_we     = 1'b0;
        ram_addr   = i_head.pid[tpcf_pkg::PID_BITS-1:0];
        ram_wdata  = '0;
        o_pop      = 1'b0;
        pass       = 1'b0;
        mark       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                // PID 0 comes up known, table kind, awaiting start
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                ram_wdata.known = (r_clr_addr == '0);
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (!i_empty) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_state = S_READ;

                n_result.status = tpcf_pkg::ST_OK;
                n_result.pid    = i_head.pid;
                n_result.kind   = 1'b0;
                n_result.start  = 1'b0;
                n_result.mark   = 1'b0;
                n_result.off    = tpcf_pkg::OFFSET_HDR;
                n_result.len    = 8'd0;

                ram_wdata.known = 1'b1;
                ram_wdata.kind  = ent.kind;
                ram_wdata.mode  = tpcf_pkg::MODE_SYNCED;
                ram_wdata.cc    = i_head.cc;

                if (i_head.op) begin
                    // Registration
                    if (ent.known) begin
                        n_result.status = tpcf_pkg::ST_ALREADY;
                        n_result.kind   = ent.kind;
                    end else begin
                        ram_we          = 1'b1;
                        ram_wdata.kind  = i_head.rkind;
                        ram_wdata.mode  = tpcf_pkg::MODE_AWAIT;
                        ram_wdata.cc    = 4'd0;
                        n_result.status = tpcf_pkg::ST_REGISTERED;
                        n_result.kind   = i_head.rkind;
                    end
                end else if (!i_head.sync_ok) begin
                    n_result.status = tpcf_pkg::ST_BADSYNC;
                end else if (!ent.known) begin
                    n_result.status = tpcf_pkg::ST_UNKNOWN;
                end else begin
                    n_result.kind  = ent.kind;
                    n_result.start = i_head.start;
                    pass           = 1'b1;
                    case (ent.mode)
                        tpcf_pkg::MODE_AWAIT: begin
                            if (i_head.start) begin
                                ram_we = 1'b1;
                            end else begin
                                n_result.status = tpcf_pkg::ST_AWAIT;
                                pass            = 1'b0;
                            end
                        end
                        tpcf_pkg::MODE_LOST: begin
                            if (i_head.start) begin
                                ram_we = 1'b1;
                                mark   = 1'b1;
                            end else begin
                                n_result.status = tpcf_pkg::ST_UNSYNCED;
                                pass            = 1'b0;
                            end
                        end
                        default: begin
                            // Synced; counter must advance by one
                            ram_we = 1'b1;
                            if (i_head.cc != cc_next) begin
                                if (i_head.start) begin
                                    mark = 1'b1;
                                end else begin
                                    ram_wdata.mode  = tpcf_pkg::MODE_LOST;
                                    ram_wdata.cc    = ent.cc;
                                    n_result.status = tpcf_pkg::ST_DISCONT;
                                    pass            = 1'b0;
                                end
                            end
                        end
                    endcase

                    if (pass) begin
                        n_result.mark = mark;
                        n_result.off  = i_head.off;
                        n_result.len  = i_head.len;
                        if (i_head.adapt_long) begin
                            n_result.status = tpcf_pkg::ST_ADAPT_LONG;
                        end else if (mark) begin
                            n_result.status = tpcf_pkg::ST_RESYNC;
                        end
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
        end
    end

    // Result register, no reset
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_valid;
    assign o_result   = r_result;

endmodule

FILE: rtl/core/ts_packet_continuity_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_packet_continuity_filter_unit - TS PID filter with continuity check
// Checks header fields of transport packets against a per-PID table and
// registers PIDs.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the item fields with start high; the transfer
//   happens on a rising edge with start high and busy low. i_op selects a
//   packet header (0) or a PID registration (1).
//   Result channel: one result per item, shown for one cycle with o_valid
//   high; the receiver cannot stall it.
//   Pipeline: the front classifier feeds a two-entry queue; the table
//   sequencer takes one item at a time, reads its entry in the read state,
//   updates it in the exec state with a write on the single table port
//   where needed, and registers the result. The queue takes new items while
//   the sequencer works on earlier ones, and busy rises while it is full.
//   Reset: synchronous, active low. After reset the sequencer sweeps the
//   8192-entry PID table, one entry per cycle, leaving only PID 0 known
//   (table kind, awaiting start); busy stays high meanwhile.
// ----------------------------------------------------------------------------
module ts_packet_continuity_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [7:0]  i_sync_byte,
    input  logic        i_payload_start,
    input  logic [12:0] i_pid,
    input  logic [1:0]  i_adaptation_control,
    input  logic [3:0]  i_continuity,
    input  logic [7:0]  i_adaptation_length,
    input  logic        i_register_kind,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [12:0] o_pid_out,
    output logic        o_pid_kind,
    output logic        o_start_out,
    output logic        o_resync_mark,
    output logic [7:0]  o_payload_offset,
    output logic [7:0]  o_payload_length
);

    tpcf_pkg::t_item   item;
    tpcf_pkg::t_item   head;
    tpcf_pkg::t_q_stat q_stat;
    tpcf_pkg::t_result result;
    logic              push;
    logic              pop;
    logic              clearing;

    // Command transfer
    assign busy = clearing || q_stat.full;
    assign push = start && !busy;

    tpcf_front u_front (
        .i_op                 (i_op),
        .i_sync_byte          (i_sync_byte),
        .i_payload_start      (i_payload_start),
        .i_pid                (i_pid),
        .i_adaptation_control (i_adaptation_control),
        .i_continuity         (i_continuity),
        .i_adaptation_length  (i_adaptation_length),
        .i_register_kind      (i_register_kind),
        .o_item               (item)
    );

    tpcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tpcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_empty    (q_stat.empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_result   (result)
    );

    // Result ports
    assign o_status         = result.status;
    assign o_pid_out        = result.pid;
    assign o_pid_kind       = result.kind;
    assign o_start_out      = result.start;
    assign o_resync_mark    = result.mark;
    assign o_payload_offset = result.off;
    assign o_payload_length = result.len;

endmodule
